@@ hw/rtl/string_literal_unescaper_defines.svh @@
// Assertion macros used by slu_outbuf.
`ifndef STRING_LITERAL_UNESCAPER_DEFINES_SVH
`define STRING_LITERAL_UNESCAPER_DEFINES_SVH

// Checks that an expression holds at every clock edge outside reset.
`define SLU_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("slu assertion failed");

// Checks that a consequent holds in the same cycle as its antecedent.
`define SLU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slu assertion failed");

`endif

@@ hw/rtl/slu_pkg.sv @@
package slu_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_OCTAL  = 2'd2
    } t_mode;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_END      = 2'd1;
    localparam logic [1:0] ERR_ILLEGAL  = 2'd2;
    localparam logic [1:0] ERR_UNCLOSED = 2'd3;

    localparam logic       CFG_QUOTE_CHAR     = 1'b0;
    localparam logic       CFG_CLOSE_REQUIRED = 1'b1;

    localparam logic [7:0] QUOTE_RESET = 8'd34;
    localparam logic       CLOSE_REQUIRED_RESET = 1'b1;

    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_BS         = 8'h08;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_FF         = 8'h0C;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_APOS       = 8'h27;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_SEVEN      = 8'h37;
    localparam logic [7:0] CH_N          = 8'h6E;
    localparam logic [7:0] CH_R          = 8'h72;
    localparam logic [7:0] CH_B          = 8'h62;
    localparam logic [7:0] CH_T          = 8'h74;
    localparam logic [7:0] CH_F          = 8'h66;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_out;
        logic [1:0] error_code;
        logic       last;
    } t_out_item;

    // Everything one decode step produces.
    typedef struct packed {
        logic [1:0] nres;
        t_out_item  res0;
        t_out_item  res1;
        t_mode      next_mode;
        logic [7:0] next_octal;
    } t_dec_result;

    function automatic t_out_item mk_item(logic [1:0] kind, logic [7:0] b, logic [1:0] err);
        t_out_item it;
        it.kind       = kind;
        it.byte_out   = b;
        it.error_code = err;
        it.last       = 1'b0;
        return it;
    endfunction

endpackage

@@ hw/rtl/string_literal_unescaper.sv @@
// An accepted byte is registered, decoded combinationally, and its results are
// registered into the output buffer once that buffer can take the step.
// Throughput: one input per cycle when the buffer has room; a step that yields two
// results holds the two-entry result buffer for two output transfers.
// Reset (synchronous, active low) empties both stages, sets normal mode, clears the
// octal accumulator and restores quote 34 and close-required 1.
module string_literal_unescaper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  slu_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output slu_pkg::t_out_item o_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    logic                 r_in_valid;
    slu_pkg::t_in_item    r_in;
    slu_pkg::t_mode       r_mode;
    logic [7:0]           r_octal;
    logic [7:0]           r_quote_char;
    logic                 r_close_required;
    slu_pkg::t_dec_result dec;
    logic                 load_ready;
    logic                 fire;

    assign fire    = r_in_valid && load_ready;
    assign o_ready = !r_in_valid || fire;

    slu_decode u_decode (
        .i_mode           (r_mode),
        .i_octal          (r_octal),
        .i_quote_char     (r_quote_char),
        .i_close_required (r_close_required),
        .i_item           (r_in),
        .o_result         (dec)
    );

    slu_outbuf u_outbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (fire),
        .i_nres       (dec.nres),
        .i_res0       (dec.res0),
        .i_res1       (dec.res1),
        .o_load_ready (load_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_mode           <= slu_pkg::MODE_NORMAL;
            r_octal          <= 8'd0;
            r_quote_char     <= slu_pkg::QUOTE_RESET;
            r_close_required <= slu_pkg::CLOSE_REQUIRED_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_mode  <= dec.next_mode;
                r_octal <= dec.next_octal;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    slu_pkg::CFG_QUOTE_CHAR:     r_quote_char     <= i_cfg_data;
                    slu_pkg::CFG_CLOSE_REQUIRED: r_close_required <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

endmodule

@@ hw/rtl/slu_decode.sv @@
module slu_decode (
    input  slu_pkg::t_mode       i_mode,
    input  logic [7:0]           i_octal,
    input  logic [7:0]           i_quote_char,
    input  logic                 i_close_required,
    input  slu_pkg::t_in_item    i_item,
    output slu_pkg::t_dec_result o_result
);

    logic [7:0]         c;
    logic               eot;
    logic               is_oct;
    logic               nb_has;
    slu_pkg::t_out_item nb_item;
    slu_pkg::t_mode     nb_mode;
    slu_pkg::t_dec_result res;

    assign c      = i_item.char_in;
    assign eot    = i_item.end_of_text;
    assign is_oct = (c >= slu_pkg::CH_ZERO) && (c <= slu_pkg::CH_SEVEN);

    // Outcome of a byte or end of text seen in normal mode.
    always_comb begin
        nb_has  = 1'b0;
        nb_item = slu_pkg::mk_item(slu_pkg::KIND_BYTE, 8'd0, slu_pkg::ERR_NONE);
        nb_mode = slu_pkg::MODE_NORMAL;
        if (eot) begin
            nb_has = 1'b1;
            if (i_close_required) begin
                nb_item = slu_pkg::mk_item(slu_pkg::KIND_ERROR, 8'd0, slu_pkg::ERR_END);
            end else begin
                nb_item = slu_pkg::mk_item(slu_pkg::KIND_CLOSE, 8'd0, slu_pkg::ERR_NONE);
            end
        end else if (c == i_quote_char) begin
            nb_has  = 1'b1;
            nb_item = slu_pkg::mk_item(slu_pkg::KIND_CLOSE, 8'd0, slu_pkg::ERR_NONE);
        end else if (c == slu_pkg::CH_BACKSLASH) begin
            nb_mode = slu_pkg::MODE_ESCAPE;
        end else if (c == slu_pkg::CH_NEWLINE && i_close_required) begin
            nb_has  = 1'b1;
            nb_item = slu_pkg::mk_item(slu_pkg::KIND_ERROR, 8'd0, slu_pkg::ERR_UNCLOSED);
        end else begin
            nb_has  = 1'b1;
            nb_item = slu_pkg::mk_item(slu_pkg::KIND_BYTE, c, slu_pkg::ERR_NONE);
        end
    end

    always_comb begin
        res.nres       = 2'd0;
        res.res0       = slu_pkg::mk_item(slu_pkg::KIND_BYTE, 8'd0, slu_pkg::ERR_NONE);
        res.res1       = slu_pkg::mk_item(slu_pkg::KIND_BYTE, 8'd0, slu_pkg::ERR_NONE);
        res.next_mode  = i_mode;
        res.next_octal = i_octal;
        case (i_mode)
            slu_pkg::MODE_OCTAL: begin
                if (!eot && c == slu_pkg::CH_UNDERSCORE) begin
                    res.nres = 2'd0;
                end else if (!eot && is_oct) begin
                    res.next_octal = {i_octal[4:0], c[2:0]};
                end else begin
                    // The pending value goes out first, then the byte is seen as normal.
                    res.res0       = slu_pkg::mk_item(slu_pkg::KIND_BYTE, i_octal,
                                                      slu_pkg::ERR_NONE);
                    res.next_octal = 8'd0;
                    res.next_mode  = nb_mode;
                    if (nb_has) begin
                        res.res1 = nb_item;
                        res.nres = 2'd2;
                    end else begin
                        res.nres = 2'd1;
                    end
                end
            end
            slu_pkg::MODE_ESCAPE: begin
                res.next_octal = 8'd0;
                res.next_mode  = slu_pkg::MODE_NORMAL;
                if (eot) begin
                    res.nres = 2'd1;
                    res.res0 = slu_pkg::mk_item(slu_pkg::KIND_ERROR, 8'd0, slu_pkg::ERR_END);
                end else if (is_oct) begin
                    res.next_mode  = slu_pkg::MODE_OCTAL;
                    res.next_octal = {5'd0, c[2:0]};
                end else begin
                    res.nres = 2'd1;
                    case (c)
                        slu_pkg::CH_N: res.res0.byte_out = slu_pkg::CH_NEWLINE;
                        slu_pkg::CH_R: res.res0.byte_out = slu_pkg::CH_CR;
                        slu_pkg::CH_B: res.res0.byte_out = slu_pkg::CH_BS;
                        slu_pkg::CH_T: res.res0.byte_out = slu_pkg::CH_TAB;
                        slu_pkg::CH_F: res.res0.byte_out = slu_pkg::CH_FF;
                        slu_pkg::CH_APOS, slu_pkg::CH_DQUOTE,
                        slu_pkg::CH_BACKSLASH, slu_pkg::CH_SLASH: res.res0.byte_out = c;
                        slu_pkg::CH_NEWLINE: res.nres = 2'd0;
                        default: begin
                            res.res0 = slu_pkg::mk_item(slu_pkg::KIND_ERROR, 8'd0,
                                                        slu_pkg::ERR_ILLEGAL);
                        end
                    endcase
                end
            end
            default: begin
                res.next_octal = 8'd0;
                res.next_mode  = nb_mode;
                if (nb_has) begin
                    res.nres = 2'd1;
                    res.res0 = nb_item;
                end
            end
        endcase
        if (res.nres == 2'd1) begin
            res.res0.last = 1'b1;
        end
        if (res.nres == 2'd2) begin
            res.res1.last = 1'b1;
        end
    end

    assign o_result = res;

endmodule

@@ hw/rtl/slu_outbuf.sv @@
`include "string_literal_unescaper_defines.svh"

module slu_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [1:0]         i_nres,
    input  slu_pkg::t_out_item i_res0,
    input  slu_pkg::t_out_item i_res1,
    output logic               o_load_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output slu_pkg::t_out_item o_data
);

    logic [1:0]         r_cnt;
    logic [1:0]         n_cnt;
    slu_pkg::t_out_item r_slot0;
    slu_pkg::t_out_item r_slot1;
    slu_pkg::t_out_item n_slot0;
    slu_pkg::t_out_item n_slot1;
    logic               pop;

    assign o_valid      = (r_cnt != 2'd0);
    assign o_data       = r_slot0;
    assign pop          = o_valid && i_ready;
    // A new step may land when the buffer is empty or drains this cycle.
    assign o_load_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (i_load) begin
            n_cnt   = i_nres;
            n_slot0 = i_res0;
            n_slot1 = i_res1;
        end else if (pop) begin
            n_cnt   = r_cnt - 2'd1;
            n_slot0 = r_slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    `SLU_ASSERT(a_cnt_range, r_cnt != 2'd3)
    `SLU_ASSERT_IMP(a_single_last, r_cnt == 2'd1, r_slot0.last)
    `SLU_ASSERT_IMP(a_pair_last, r_cnt == 2'd2, !r_slot0.last && r_slot1.last)
    `SLU_ASSERT_IMP(a_byte_no_err, o_valid && r_slot0.kind == slu_pkg::KIND_BYTE,
                    r_slot0.error_code == slu_pkg::ERR_NONE)

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 120;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    slu_pkg::t_in_item  i_data = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    slu_pkg::t_out_item o_data;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [7:0]         i_cfg_data = '0;

    string_literal_unescaper u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder state mirrored by the testbench.
    slu_pkg::t_mode dec_mode = slu_pkg::MODE_NORMAL;
    logic [7:0]     oct_acc = '0;
    logic [7:0]     cfg_quote = slu_pkg::QUOTE_RESET;
    logic           cfg_close = slu_pkg::CLOSE_REQUIRED_RESET;

    slu_pkg::t_out_item expected_out[$];
    int         error_count = 0;
    int         items_sent = 0;
    int         cycle_count = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         hold_requests = 0;

    logic [7:0] esc_letters[10] = '{slu_pkg::CH_N, slu_pkg::CH_R, slu_pkg::CH_B,
                                    slu_pkg::CH_T, slu_pkg::CH_F, slu_pkg::CH_APOS,
                                    slu_pkg::CH_DQUOTE, slu_pkg::CH_BACKSLASH,
                                    slu_pkg::CH_SLASH, slu_pkg::CH_NEWLINE};

    function automatic void push_result(logic [1:0] kind, logic [7:0] b, logic [1:0] err);
        expected_out.push_back('{kind: kind, byte_out: b, error_code: err, last: 1'b0});
        // A close or an error starts a fresh literal body.
        if (kind != slu_pkg::KIND_BYTE) begin
            dec_mode = slu_pkg::MODE_NORMAL;
            oct_acc  = '0;
        end
    endfunction

    function automatic void decode_plain(logic [7:0] c);
        if (c == cfg_quote)
            push_result(slu_pkg::KIND_CLOSE, 8'h00, slu_pkg::ERR_NONE);
        else if (c == slu_pkg::CH_BACKSLASH)
            dec_mode = slu_pkg::MODE_ESCAPE;
        else if (c == slu_pkg::CH_NEWLINE && cfg_close)
            push_result(slu_pkg::KIND_ERROR, 8'h00, slu_pkg::ERR_UNCLOSED);
        else
            push_result(slu_pkg::KIND_BYTE, c, slu_pkg::ERR_NONE);
    endfunction

    function automatic void decode_end();
        if (cfg_close)
            push_result(slu_pkg::KIND_ERROR, 8'h00, slu_pkg::ERR_END);
        else
            push_result(slu_pkg::KIND_CLOSE, 8'h00, slu_pkg::ERR_NONE);
    endfunction

    function automatic void predict_step(slu_pkg::t_in_item it);
        int                 before_count;
        logic [7:0]         c;
        logic               eot;
        logic               is_oct_digit;
        slu_pkg::t_out_item tail;
        before_count = expected_out.size();
        c = it.char_in;
        eot = it.end_of_text;
        is_oct_digit = (c >= slu_pkg::CH_ZERO && c <= slu_pkg::CH_SEVEN);
        case (dec_mode)
            slu_pkg::MODE_OCTAL: begin
                if (!eot && c == slu_pkg::CH_UNDERSCORE) begin
                end else if (!eot && is_oct_digit) begin
                    oct_acc = (oct_acc << 3) + (c - slu_pkg::CH_ZERO);
                end else begin
                    push_result(slu_pkg::KIND_BYTE, oct_acc, slu_pkg::ERR_NONE);
                    dec_mode = slu_pkg::MODE_NORMAL;
                    oct_acc  = '0;
                    if (eot)
                        decode_end();
                    else
                        decode_plain(c);
                end
            end
            slu_pkg::MODE_ESCAPE: begin
                if (eot) begin
                    push_result(slu_pkg::KIND_ERROR, 8'h00, slu_pkg::ERR_END);
                end else if (is_oct_digit) begin
                    dec_mode = slu_pkg::MODE_OCTAL;
                    oct_acc  = c - slu_pkg::CH_ZERO;
                end else begin
                    dec_mode = slu_pkg::MODE_NORMAL;
                    case (c)
                        slu_pkg::CH_N:
                            push_result(slu_pkg::KIND_BYTE, slu_pkg::CH_NEWLINE,
                                        slu_pkg::ERR_NONE);
                        slu_pkg::CH_R:
                            push_result(slu_pkg::KIND_BYTE, slu_pkg::CH_CR, slu_pkg::ERR_NONE);
                        slu_pkg::CH_B:
                            push_result(slu_pkg::KIND_BYTE, slu_pkg::CH_BS, slu_pkg::ERR_NONE);
                        slu_pkg::CH_T:
                            push_result(slu_pkg::KIND_BYTE, slu_pkg::CH_TAB, slu_pkg::ERR_NONE);
                        slu_pkg::CH_F:
                            push_result(slu_pkg::KIND_BYTE, slu_pkg::CH_FF, slu_pkg::ERR_NONE);
                        slu_pkg::CH_APOS, slu_pkg::CH_DQUOTE, slu_pkg::CH_BACKSLASH,
                        slu_pkg::CH_SLASH:
                            push_result(slu_pkg::KIND_BYTE, c, slu_pkg::ERR_NONE);
                        slu_pkg::CH_NEWLINE: begin
                            // Line continuation inside the literal yields nothing.
                        end
                        default:
                            push_result(slu_pkg::KIND_ERROR, 8'h00, slu_pkg::ERR_ILLEGAL);
                    endcase
                end
            end
            default: begin
                if (eot)
                    decode_end();
                else
                    decode_plain(c);
            end
        endcase
        if (expected_out.size() > before_count) begin
            tail = expected_out.pop_back();
            tail.last = 1'b1;
            expected_out.push_back(tail);
        end
    endfunction

    function automatic void check_result(slu_pkg::t_out_item got);
        slu_pkg::t_out_item want;
        if (expected_out.size() == 0) begin
            $display("%0t: result with nothing expected: kind %0d byte %h err %0d last %0d",
                     $time, got.kind, got.byte_out, got.error_code, got.last);
            error_count++;
        end else begin
            want = expected_out.pop_front();
            if (got.kind !== want.kind || got.byte_out !== want.byte_out ||
                got.error_code !== want.error_code || got.last !== want.last) begin
                $display("%0t: mismatch: expected kind %0d byte %h err %0d last %0d,",
                         $time, want.kind, want.byte_out, want.error_code, want.last);
                $display("%0t:           got kind %0d byte %h err %0d last %0d",
                         $time, got.kind, got.byte_out, got.error_code, got.last);
                error_count++;
            end
        end
    endfunction

    // Output side: checks each transfer and drives ready, with an occasional long hold-off.
    always @(posedge i_clk) begin
        int holds_taken;
        int hold_left;
        if (i_rst_n && o_valid && i_ready)
            check_result(o_data);
        if (hold_requests != holds_taken) begin
            holds_taken = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_out.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(slu_pkg::t_in_item it);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        predict_step(it);
    endtask

    task automatic send_char(logic [7:0] c);
        send_item('{char_in: c, end_of_text: 1'b0});
    endtask

    task automatic send_eot();
        send_item('{char_in: 8'($urandom), end_of_text: 1'b1});
    endtask

    // Stops offering input and waits until every expected result has come out.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [7:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == slu_pkg::CFG_QUOTE_CHAR)
            cfg_quote = value;
        else
            cfg_close = value[0];
    endtask

    task automatic test_directed_defaults();
        send_char(8'h41);
        send_char(8'h00);
        send_char(slu_pkg::CH_BACKSLASH); send_char(slu_pkg::CH_N);
        send_char(slu_pkg::CH_BACKSLASH); send_char(slu_pkg::CH_APOS);
        send_char(slu_pkg::CH_BACKSLASH); send_char(slu_pkg::CH_BACKSLASH);
        send_char(slu_pkg::CH_BACKSLASH); send_char(slu_pkg::CH_SLASH);
        send_char(slu_pkg::CH_BACKSLASH); send_char(slu_pkg::CH_NEWLINE);
        send_char(slu_pkg::CH_BACKSLASH); send_char(8'h71);
        // Octal 3_77 gives 0xFF, then a digit 8 ends it and passes as a byte.
        send_char(slu_pkg::CH_BACKSLASH); send_char(8'h33); send_char(slu_pkg::CH_UNDERSCORE);
        send_char(slu_pkg::CH_SEVEN); send_char(slu_pkg::CH_SEVEN); send_char(8'h38);
        send_char(slu_pkg::CH_DQUOTE);
        send_char(slu_pkg::CH_NEWLINE);
        send_eot();
        send_char(slu_pkg::CH_BACKSLASH); send_eot();
        send_char(slu_pkg::CH_BACKSLASH); send_char(slu_pkg::CH_SEVEN);
        send_char(slu_pkg::CH_UNDERSCORE); send_eot();
        // Octal ended by the quote gives a byte and a close in one step.
        send_char(slu_pkg::CH_BACKSLASH); send_char(slu_pkg::CH_ZERO);
        send_char(slu_pkg::CH_DQUOTE);
    endtask

    task automatic test_config_extremes();
        write_cfg(slu_pkg::CFG_CLOSE_REQUIRED, 8'h00);
        write_cfg(slu_pkg::CFG_QUOTE_CHAR, 8'h00);
        send_char(slu_pkg::CH_NEWLINE);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(slu_pkg::CH_BACKSLASH); send_char(slu_pkg::CH_R);
        send_eot();
        write_cfg(slu_pkg::CFG_QUOTE_CHAR, 8'hFF);
        send_char(8'hFF);
        // With the quote set to backslash, a bare backslash closes the literal.
        write_cfg(slu_pkg::CFG_QUOTE_CHAR, slu_pkg::CH_BACKSLASH);
        send_char(slu_pkg::CH_BACKSLASH);
        send_char(slu_pkg::CH_DQUOTE);
        write_cfg(slu_pkg::CFG_CLOSE_REQUIRED, 8'h01);
        write_cfg(slu_pkg::CFG_QUOTE_CHAR, slu_pkg::CH_NEWLINE);
        send_char(slu_pkg::CH_NEWLINE);
        write_cfg(slu_pkg::CFG_QUOTE_CHAR, slu_pkg::QUOTE_RESET);
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        repeat (40) send_char(8'($urandom_range(32, 126)));
        drain();
    endtask

    // One piece of a literal body, mostly well formed.
    task automatic send_fragment();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 40) begin
            send_char(8'($urandom_range(32, 126)));
        end else if (pick < 58) begin
            send_char(slu_pkg::CH_BACKSLASH);
            send_char(esc_letters[$urandom_range(9)]);
        end else if (pick < 72) begin
            send_char(slu_pkg::CH_BACKSLASH);
            send_char(8'($urandom_range(slu_pkg::CH_ZERO, slu_pkg::CH_SEVEN)));
            n = $urandom_range(4);
            repeat (n) begin
                if ($urandom_range(3) == 0)
                    send_char(slu_pkg::CH_UNDERSCORE);
                else
                    send_char(8'($urandom_range(slu_pkg::CH_ZERO, slu_pkg::CH_SEVEN)));
            end
            if ($urandom_range(3) == 0)
                send_char(8'($urandom_range(8'h38, 8'h39)));
        end else if (pick < 78) begin
            send_char(cfg_quote);
        end else if (pick < 81) begin
            send_char(slu_pkg::CH_NEWLINE);
        end else if (pick < 84) begin
            send_eot();
        end else if (pick < 89) begin
            send_char(slu_pkg::CH_BACKSLASH);
            send_char(8'($urandom));
        end else begin
            if ($urandom_range(9) == 0)
                send_eot();
            else
                send_char(8'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        int target;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    write_cfg(slu_pkg::CFG_QUOTE_CHAR, slu_pkg::QUOTE_RESET);
                    write_cfg(slu_pkg::CFG_CLOSE_REQUIRED, 8'h01);
                    tx_idle_pct = 6;
                    rx_idle_pct = 85;
                end
                1: begin
                    write_cfg(slu_pkg::CFG_QUOTE_CHAR, slu_pkg::CH_APOS);
                    write_cfg(slu_pkg::CFG_CLOSE_REQUIRED, 8'h00);
                    tx_idle_pct = 85;
                    rx_idle_pct = 6;
                end
                default: begin
                    write_cfg(slu_pkg::CFG_QUOTE_CHAR,
                              $urandom_range(1) ? slu_pkg::QUOTE_RESET : 8'($urandom));
                    write_cfg(slu_pkg::CFG_CLOSE_REQUIRED, 8'($urandom_range(1)));
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            target = items_sent + 430;
            while (items_sent < target) begin
                send_fragment();
                if (phase == 2 && items_sent >= target - 200 && hold_requests == 1)
                    hold_requests++;
            end
            drain();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_defaults();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        drain();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_out.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
